// ===== sv/tspf_pkg.sv =====
// Shared types and constants for the transport stream PID filter.
package tspf_pkg;

    localparam int FILTER_SLOTS = 8;
    localparam int PACKET_BYTES = 188;
    localparam int SLOT_W = (FILTER_SLOTS > 1) ? $clog2(FILTER_SLOTS) : 1;

    localparam logic [7:0] SYNC_BYTE = 8'h47;
    localparam logic [7:0] LAST_POS = 8'(PACKET_BYTES - 1);
    localparam logic [11:0] HUNT_LIMIT_RESET = 12'(2 * 1024);

    typedef enum logic [2:0] {
        ST_PAYLOAD   = 3'd0,
        ST_INSTALLED = 3'd1,
        ST_DUPLICATE = 3'd2,
        ST_FULL      = 3'd3,
        ST_SYNC_LOST = 3'd4
    } status_t;

    typedef enum logic {
        CFG_PID_LOCK   = 1'b0,
        CFG_HUNT_LIMIT = 1'b1
    } cfg_idx_t;

    // Requests from the engine to the slot table
    typedef struct packed {
        logic [12:0]       lookup_pid;
        logic              install_en;
        logic              install_kind;
        logic              cnt_we;
        logic [3:0]        cnt_value;
        logic [SLOT_W-1:0] rd_slot;
    } tbl_req_t;

    // Slot table answers, all combinational
    typedef struct packed {
        logic              match_hit;
        logic [SLOT_W-1:0] match_slot;
        logic              free_hit;
        logic [SLOT_W-1:0] free_slot;
        logic              rd_kind;
        logic [4:0]        rd_last;
    } tbl_rsp_t;

    typedef struct packed {
        logic        valid;
        status_t     status;
        logic [7:0]  payload_byte;
        logic [2:0]  slot_index;
        logic        slot_kind;
        logic        unit_start;
        logic        continuity_error;
        logic        last_of_packet;
    } result_t;

endpackage

// ===== sv/tspf_slot_table.sv =====
// Filter slot table: PID compare over all slots, install and per-slot counter.
module tspf_slot_table (
    input  logic               aclk,
    input  logic               aresetn,
    input  tspf_pkg::tbl_req_t req,
    output tspf_pkg::tbl_rsp_t rsp
);
    import tspf_pkg::*;

    logic [FILTER_SLOTS-1:0] valid_reg;
    logic [12:0]             pid_reg  [FILTER_SLOTS];
    logic                    kind_reg [FILTER_SLOTS];
    logic [4:0]              last_reg [FILTER_SLOTS];

    // Lowest matching slot and lowest free slot
    always_comb begin
        rsp.match_hit  = 1'b0;
        rsp.match_slot = '0;
        rsp.free_hit   = 1'b0;
        rsp.free_slot  = '0;
        for (int i = FILTER_SLOTS - 1; i >= 0; i--) begin
            if (valid_reg[i] && pid_reg[i] == req.lookup_pid) begin
                rsp.match_hit  = 1'b1;
                rsp.match_slot = SLOT_W'(i);
            end
            if (!valid_reg[i]) begin
                rsp.free_hit  = 1'b1;
                rsp.free_slot = SLOT_W'(i);
            end
        end
        rsp.rd_kind = kind_reg[req.rd_slot];
        rsp.rd_last = last_reg[req.rd_slot];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (req.install_en && !rsp.match_hit && rsp.free_hit) begin
            valid_reg[rsp.free_slot] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (req.install_en && !rsp.match_hit && rsp.free_hit) begin
            pid_reg[rsp.free_slot]  <= req.lookup_pid;
            kind_reg[rsp.free_slot] <= req.install_kind;
            last_reg[rsp.free_slot] <= 5'h10;   // no counter seen yet
        end else if (req.cnt_we) begin
            last_reg[req.rd_slot] <= {1'b0, req.cnt_value};
        end
    end

endmodule

// ===== sv/tspf_engine.sv =====
// Sync hunt, packet framing, header decode and payload selection for one item.
module tspf_engine (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               step,
    input  logic               req_type,
    input  logic [7:0]         data_byte,
    input  logic [12:0]        filter_pid,
    input  logic               filter_kind,
    input  logic [12:0]        pid_lock,
    input  logic [11:0]        sync_hunt_limit,
    output tspf_pkg::tbl_req_t tbl_req,
    input  tspf_pkg::tbl_rsp_t tbl_rsp,
    output tspf_pkg::result_t  res
);
    import tspf_pkg::*;

    logic              hunting_reg,  hunting_next;
    logic [11:0]       hunt_cnt_reg, hunt_cnt_next;
    logic [7:0]        pos_reg,      pos_next;
    logic [4:0]        pid_hi_reg,   pid_hi_next;
    logic              start_reg,    start_next;
    logic [1:0]        afc_reg,      afc_next;
    logic              ccerr_reg,    ccerr_next;
    logic              live_reg,     live_next;
    logic              ptr_reg,      ptr_next;
    logic              sent_reg,     sent_next;
    logic [SLOT_W-1:0] hit_reg,      hit_next;
    logic [8:0]        pb_reg,       pb_next;

    logic [12:0] hunt_sum;
    logic [12:0] hdr_pid;
    logic [1:0]  ad_ctl;
    logic [3:0]  cc_exp;
    logic        cc_now;
    logic        cnt_we;

    assign hunt_sum = {1'b0, hunt_cnt_reg} + 13'd1;
    assign hdr_pid  = {pid_hi_reg, data_byte};
    assign ad_ctl   = data_byte[5:4];
    assign cc_exp   = tbl_rsp.rd_last[3:0] + {3'd0, ad_ctl[0]};

    always_comb begin
        tbl_req.lookup_pid   = req_type ? filter_pid : hdr_pid;
        tbl_req.install_kind = filter_kind;
        tbl_req.install_en   = step && req_type;
        tbl_req.cnt_we       = cnt_we;
        tbl_req.cnt_value    = data_byte[3:0];
        tbl_req.rd_slot      = hit_reg;
    end

    always_comb begin
        hunting_next  = hunting_reg;
        hunt_cnt_next = hunt_cnt_reg;
        pos_next      = pos_reg;
        pid_hi_next   = pid_hi_reg;
        start_next    = start_reg;
        afc_next      = afc_reg;
        ccerr_next    = ccerr_reg;
        live_next     = live_reg;
        ptr_next      = ptr_reg;
        sent_next     = sent_reg;
        hit_next      = hit_reg;
        pb_next       = pb_reg;
        cc_now        = ccerr_reg;
        cnt_we        = 1'b0;

        res                  = '0;
        res.status           = ST_PAYLOAD;
        res.slot_kind        = filter_kind;

        if (step && req_type) begin
            res.valid = 1'b1;
            if (tbl_rsp.match_hit) begin
                res.status     = ST_DUPLICATE;
                res.slot_index = 3'(tbl_rsp.match_slot);
            end else if (tbl_rsp.free_hit) begin
                res.status     = ST_INSTALLED;
                res.slot_index = 3'(tbl_rsp.free_slot);
            end else begin
                res.status     = ST_FULL;
            end
        end else if (step && hunting_reg) begin
            if (data_byte == SYNC_BYTE) begin
                hunting_next  = 1'b0;
                hunt_cnt_next = '0;
                pos_next      = 8'd1;
            end else if (hunt_sum >= {1'b0, sync_hunt_limit}) begin
                hunt_cnt_next = '0;
                res.valid     = 1'b1;
                res.status    = ST_SYNC_LOST;
                res.slot_kind = 1'b0;
            end else begin
                hunt_cnt_next = hunt_sum[11:0];
            end
        end else if (step) begin
            if (pos_reg == 8'd1) begin
                pid_hi_next = data_byte[4:0];
                start_next  = data_byte[6];
                afc_next    = '0;
                ccerr_next  = 1'b0;
                live_next   = 1'b0;
                ptr_next    = 1'b0;
                sent_next   = 1'b0;
                hit_next    = '0;
            end else if (pos_reg == 8'd2) begin
                if ((pid_lock == '0 || pid_lock == hdr_pid) && tbl_rsp.match_hit) begin
                    hit_next  = tbl_rsp.match_slot;
                    live_next = 1'b1;
                end
            end else if (pos_reg == 8'd3) begin
                if (live_reg) begin
                    if (ad_ctl == 2'd0) begin
                        live_next = 1'b0;
                    end else begin
                        if (!tbl_rsp.rd_last[4] && cc_exp != data_byte[3:0]) begin
                            ccerr_next = 1'b1;
                        end
                        cnt_we   = 1'b1;
                        afc_next = ad_ctl;
                        pb_next  = 9'd4;
                        if (!ad_ctl[0]) begin
                            live_next = 1'b0;
                        end else if (tbl_rsp.rd_kind && start_reg) begin
                            ptr_next = 1'b1;   // section slot: skip pointer field
                        end
                    end
                end
            end else if (live_reg) begin
                if (pos_reg == 8'd4 && afc_reg[1]) begin
                    pb_next = {1'b0, data_byte} + 9'd5;
                end else begin
                    // discontinuity indicator clears the counter error
                    if (pos_reg == 8'd5 && afc_reg[1] && pb_reg > 9'd5 && data_byte[7]) begin
                        cc_now     = 1'b0;
                        ccerr_next = 1'b0;
                    end
                    if ({1'b0, pos_reg} >= pb_reg) begin
                        if (ptr_reg) begin
                            ptr_next = 1'b0;
                            pb_next  = {1'b0, pos_reg} + {1'b0, data_byte} + 9'd1;
                        end else begin
                            res.valid            = 1'b1;
                            res.status           = ST_PAYLOAD;
                            res.payload_byte     = data_byte;
                            res.slot_index       = 3'(hit_reg);
                            res.slot_kind        = tbl_rsp.rd_kind;
                            res.unit_start       = start_reg && !sent_reg;
                            res.continuity_error = cc_now;
                            res.last_of_packet   = (pos_reg == LAST_POS);
                            sent_next            = 1'b1;
                        end
                    end
                end
            end

            if (pos_reg >= LAST_POS) begin
                hunting_next  = 1'b1;
                hunt_cnt_next = '0;
                pos_next      = '0;
            end else begin
                pos_next = pos_reg + 8'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hunting_reg  <= 1'b1;
            hunt_cnt_reg <= '0;
            pos_reg      <= '0;
            start_reg    <= 1'b0;
            afc_reg      <= '0;
            ccerr_reg    <= 1'b0;
            live_reg     <= 1'b0;
            ptr_reg      <= 1'b0;
            sent_reg     <= 1'b0;
            hit_reg      <= '0;
            pb_reg       <= '0;
            pid_hi_reg   <= '0;
        end else begin
            hunting_reg  <= hunting_next;
            hunt_cnt_reg <= hunt_cnt_next;
            pos_reg      <= pos_next;
            start_reg    <= start_next;
            afc_reg      <= afc_next;
            ccerr_reg    <= ccerr_next;
            live_reg     <= live_next;
            ptr_reg      <= ptr_next;
            sent_reg     <= sent_next;
            hit_reg      <= hit_next;
            pb_reg       <= pb_next;
            pid_hi_reg   <= pid_hi_next;
        end
    end

    a_hunt_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        hunting_reg |-> pos_reg == '0)
        else $error("byte position nonzero while hunting");

    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= LAST_POS)
        else $error("byte position past packet end");

    a_ptr_live: assert property (@(posedge aclk) disable iff (!aresetn)
        ptr_reg && pos_reg > 8'd3 |-> live_reg)
        else $error("pointer field pending on a dropped packet");

    a_payload_src: assert property (@(posedge aclk) disable iff (!aresetn)
        res.valid && res.status == ST_PAYLOAD |-> live_reg && !hunting_reg && pos_reg > 8'd3)
        else $error("payload item outside a live packet");

endmodule

// ===== sv/ts_packet_pid_filter_core.sv =====
// MPEG-2 transport stream PID filter: top level with handshake registers.
// Accepts one item per cycle unless the result side stalls: a stream byte or a
// filter install request. An item goes from the input register through one pass
// of decode logic into the result register, where a byte's result (if any) is
// presented; the filter compare runs in parallel over all slots. A stream byte
// yields at most one result: a payload byte of a matched packet or a sync-loss
// report; an install request always yields one result. The user is to write
// registers (pid_lock, sync_hunt_limit) through the cfg port while idle; the
// block itself does not enforce this, as cfg_ready is always high.
module ts_packet_pid_filter_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [12:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_req_type,
    input  logic [7:0]  s_data_byte,
    input  logic [12:0] s_filter_pid,
    input  logic        s_filter_kind,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [7:0]  m_payload_byte,
    output logic [2:0]  m_slot_index,
    output logic        m_slot_kind,
    output logic        m_unit_start,
    output logic        m_continuity_error,
    output logic        m_last_of_packet
);
    import tspf_pkg::*;

    logic        in_valid_reg;
    logic        req_type_reg;
    logic [7:0]  data_byte_reg;
    logic [12:0] filter_pid_reg;
    logic        filter_kind_reg;
    logic [12:0] pid_lock_reg;
    logic [11:0] hunt_limit_reg;
    logic        step;
    tbl_req_t    tbl_req;
    tbl_rsp_t    tbl_rsp;
    result_t     res;
    result_t     out_reg;

    assign step      = in_valid_reg && (!out_reg.valid || m_ready);
    assign s_ready   = !in_valid_reg || step;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pid_lock_reg   <= '0;
            hunt_limit_reg <= HUNT_LIMIT_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_PID_LOCK:   pid_lock_reg   <= cfg_data;
                CFG_HUNT_LIMIT: hunt_limit_reg <= cfg_data[11:0];
                default:        pid_lock_reg   <= pid_lock_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            req_type_reg    <= s_req_type;
            data_byte_reg   <= s_data_byte;
            filter_pid_reg  <= s_filter_pid;
            filter_kind_reg <= s_filter_kind;
        end
    end

    tspf_engine u_engine (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .step            (step),
        .req_type        (req_type_reg),
        .data_byte       (data_byte_reg),
        .filter_pid      (filter_pid_reg),
        .filter_kind     (filter_kind_reg),
        .pid_lock        (pid_lock_reg),
        .sync_hunt_limit (hunt_limit_reg),
        .tbl_req         (tbl_req),
        .tbl_rsp         (tbl_rsp),
        .res             (res)
    );

    tspf_slot_table u_slots (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (tbl_req),
        .rsp     (tbl_rsp)
    );

    // Result register; valid clears once taken unless a new result lands
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_reg.valid <= 1'b0;
        end else if (step) begin
            out_reg.valid <= res.valid;
        end else if (m_ready) begin
            out_reg.valid <= 1'b0;
        end
        if (step && res.valid) begin
            out_reg.status           <= res.status;
            out_reg.payload_byte     <= res.payload_byte;
            out_reg.slot_index       <= res.slot_index;
            out_reg.slot_kind        <= res.slot_kind;
            out_reg.unit_start       <= res.unit_start;
            out_reg.continuity_error <= res.continuity_error;
            out_reg.last_of_packet   <= res.last_of_packet;
        end
    end

    assign m_valid            = out_reg.valid;
    assign m_status           = out_reg.status;
    assign m_payload_byte     = out_reg.payload_byte;
    assign m_slot_index       = out_reg.slot_index;
    assign m_slot_kind        = out_reg.slot_kind;
    assign m_unit_start       = out_reg.unit_start;
    assign m_continuity_error = out_reg.continuity_error;
    assign m_last_of_packet   = out_reg.last_of_packet;

endmodule
